FILE: rtl/core/lidar_gap_heading_defines.svh
// ----------------------------------------------------------------------------
// lidar_gap_heading assertion macros
// Shared concurrent check forms, clocked on aclk and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_GAP_HEADING_DEFINES_SVH
`define LIDAR_GAP_HEADING_DEFINES_SVH

// same-cycle implication
`define LGH_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lgh_pkg.sv
// ----------------------------------------------------------------------------
// lgh_pkg
// Widths, constants and shared types of the lidar gap heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgh_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 11;
    localparam int IDX_W        = 10;
    localparam int ANGLE_W      = 32;
    localparam int TURN_W       = 34;
    localparam int SPEED_W      = 16;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 96;

    localparam int WINDOW       = 9;
    localparam int HALF_WIN     = (WINDOW - 1) / 2;
    localparam int MAX_POINTS   = 1024;
    localparam int FIRST_CENTRE = 222;
    localparam int TAIL_GAP     = 175;
    localparam int COUNT_MAX    = 2 ** COUNT_W - 1;

    // running window sum, worked on in digits
    localparam int SUM_W        = 20;
    localparam int DIGIT_W      = 5;
    localparam int DIGITS       = SUM_W / DIGIT_W;

    // speed divide: numerator 2^43 + den/2, remainder below den
    localparam int NUM_W        = 44;
    localparam int REM_W        = 34;

    localparam logic [SAMPLE_W-1:0] FIVE_METRES = SAMPLE_W'(1280);

    typedef struct packed {
        logic [SAMPLE_W-1:0] range_floor;
        logic [SAMPLE_W-1:0] range_ceiling;
        logic [COUNT_W-1:0]  scan_points;
    } scan_cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
    } steer_cfg_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] first_best;
        logic [IDX_W-1:0] last_best;
    } hole_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/lidar_gap_heading.sv
// ----------------------------------------------------------------------------
// lidar_gap_heading
// Picks a heading towards the widest opening of a lidar scan; register port,
// sample stream in, one steering word out per scan.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata range_sample, s_tlast scan_end
//  m_        out  m_tvalid/m_tready  m_tdata idx, heading, turn rate, speed
//  apb       in   psel/penable       five registers at byte address 4*i
//
//  a sample's 20-bit window sum goes 5 bits a cycle
//  the word with s_tlast holds the input while the shift-add multiply and
//  restoring divide run; a finished result then waits in S_HOLD until the
//  output register frees up, and the input stays stalled until it does
//  reset is synchronous on aresetn low; clears scan state, presets the registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_gap_heading (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // apb register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [4:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // sample stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lgh_pkg::IN_DATA_W-1:0]    s_tdata,  // [15:0] range_sample
    input  wire logic                             s_tlast,  // scan_end
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lgh_pkg::OUT_DATA_W-1:0]        m_tdata   // [9:0] hole_index,
                                                            // [41:10] heading,
                                                            // [75:42] turn_rate,
                                                            // [91:76] forward_speed
);
    import lgh_pkg::*;

    typedef enum logic [2:0] {
        REG_FLOOR, REG_CEILING, REG_START, REG_STEP, REG_POINTS
    } reg_idx_t;

    logic [SAMPLE_W-1:0] floor_reg, floor_next;
    logic [SAMPLE_W-1:0] ceiling_reg, ceiling_next;
    logic [ANGLE_W-1:0]  start_reg, start_next;
    logic [ANGLE_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0]  points_reg, points_next;

    logic       wr_en;
    logic [2:0] reg_sel;
    scan_cfg_t  scan_cfg;
    steer_cfg_t steer_cfg;
    hole_req_t  hole_req;
    logic       steer_idle;
    logic       scan_ready;
    logic       take;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];

    always_comb begin
        floor_next   = floor_reg;
        ceiling_next = ceiling_reg;
        start_next   = start_reg;
        step_next    = step_reg;
        points_next  = points_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_FLOOR:   floor_next   = pwdata[SAMPLE_W-1:0];
                REG_CEILING: ceiling_next = pwdata[SAMPLE_W-1:0];
                REG_START:   start_next   = pwdata;
                REG_STEP:    step_next    = pwdata;
                REG_POINTS:  points_next  = pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FLOOR:   prdata = 32'(floor_reg);
            REG_CEILING: prdata = 32'(ceiling_reg);
            REG_START:   prdata = start_reg;
            REG_STEP:    prdata = step_reg;
            REG_POINTS:  prdata = 32'(points_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= '0;
            ceiling_reg <= SAMPLE_W'(65535);
            start_reg   <= '0;
            step_reg    <= '0;
            points_reg  <= COUNT_W'(720);
        end else begin
            floor_reg   <= floor_next;
            ceiling_reg <= ceiling_next;
            start_reg   <= start_next;
            step_reg    <= step_next;
            points_reg  <= points_next;
        end
    end

    assign scan_cfg.range_floor   = floor_reg;
    assign scan_cfg.range_ceiling = ceiling_reg;
    assign scan_cfg.scan_points   = points_reg;
    assign steer_cfg.start_angle  = start_reg;
    assign steer_cfg.angle_step   = step_reg;

    assign s_tready = scan_ready;
    assign take     = s_tvalid && scan_ready;

    lgh_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (scan_cfg),
        .sample_i     (s_tdata[SAMPLE_W-1:0]),
        .last_i       (s_tlast),
        .take_i       (take),
        .steer_idle_i (steer_idle),
        .ready_o      (scan_ready),
        .req_o        (hole_req)
    );

    lgh_steer u_steer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_i    (steer_cfg),
        .req_i    (hole_req),
        .idle_o   (steer_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lgh_scan.sv
// ----------------------------------------------------------------------------
// lgh_scan
// Sample window and digit-serial running sum with best-window tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_gap_heading_defines.svh"

module lgh_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lgh_pkg::scan_cfg_t            cfg_i,
    input  wire logic [lgh_pkg::SAMPLE_W-1:0]  sample_i,
    input  wire logic                          last_i,
    input  wire logic                          take_i,
    input  wire logic                          steer_idle_i,
    output logic                               ready_o,
    output lgh_pkg::hole_req_t                 req_o
);
    import lgh_pkg::*;

    typedef enum logic {S_IDLE, S_DIGIT} state_t;

    localparam logic [$clog2(DIGITS)-1:0] LAST_DIGIT = $clog2(DIGITS)'(DIGITS - 1);

    state_t                     state_reg, state_next;
    logic [$clog2(DIGITS)-1:0]  dig_reg, dig_next;
    logic [SAMPLE_W-1:0]        window_reg [WINDOW];
    logic [SAMPLE_W-1:0]        window_next [WINDOW];
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SUM_W-1:0]           new_reg, new_next;
    logic [SUM_W-1:0]           old_reg, old_next;
    logic [SUM_W-1:0]           best_reg, best_next;
    logic [1:0]                 carry_reg, carry_next;
    logic                       gt_reg, gt_next;
    logic                       eq_reg, eq_next;
    logic                       qual_reg, qual_next;
    logic                       last_reg, last_next;
    logic [IDX_W-1:0]           centre_reg, centre_next;
    logic [IDX_W-1:0]           first_reg, first_next;
    logic [IDX_W-1:0]           lastb_reg, lastb_next;
    hole_req_t                  req_reg, req_next;

    logic [SAMPLE_W-1:0]        clean;
    logic [COUNT_W-1:0]         points;
    logic                       qual;
    logic [1:0]                 carry_in;
    logic                       gt_in, eq_in;
    logic [DIGIT_W+1:0]         dsum;
    logic [DIGIT_W-1:0]         d;
    logic [DIGIT_W-1:0]         bd;
    logic                       gt_d, eq_d;
    logic                       final_dig;
    logic [SUM_W-1:0]           full_sum;
    logic [IDX_W-1:0]           first_fin, lastb_fin;

    // out-of-band samples count as five metres
    assign clean = (sample_i > cfg_i.range_floor && sample_i < cfg_i.range_ceiling)
                 ? sample_i : FIVE_METRES;

    assign points = (int'(cfg_i.scan_points) > MAX_POINTS)
                  ? COUNT_W'(MAX_POINTS) : cfg_i.scan_points;

    // centre = count - 4 must lie in [222, points - 175]
    assign qual = (count_reg >= COUNT_W'(FIRST_CENTRE + HALF_WIN))
               && (({1'b0, count_reg} + (COUNT_W+1)'(TAIL_GAP - HALF_WIN))
                   <= {1'b0, points});

    assign carry_in = (dig_reg == '0) ? 2'd1 : carry_reg;
    assign gt_in    = (dig_reg == '0) ? 1'b0 : gt_reg;
    assign eq_in    = (dig_reg == '0) ? 1'b1 : eq_reg;

    // sum + new - old, one digit per cycle, lsb first
    assign dsum = (DIGIT_W+2)'(sum_reg[DIGIT_W-1:0]) + (DIGIT_W+2)'(new_reg[DIGIT_W-1:0])
                + {2'b00, ~old_reg[DIGIT_W-1:0]} + (DIGIT_W+2)'(carry_in);
    assign d    = dsum[DIGIT_W-1:0];
    assign bd   = best_reg[DIGIT_W-1:0];

    // lsb-first compare: a higher digit overrides what the lower ones said
    assign gt_d = (d > bd) ? 1'b1 : ((d < bd) ? 1'b0 : gt_in);
    assign eq_d = eq_in && (d == bd);

    assign final_dig = (state_reg == S_DIGIT) && (dig_reg == LAST_DIGIT);
    assign full_sum  = {d, sum_reg[SUM_W-1:DIGIT_W]};

    always_comb begin
        first_fin = first_reg;
        lastb_fin = lastb_reg;
        if (qual_reg && gt_d) begin
            first_fin = centre_reg;
            lastb_fin = centre_reg;
        end else if (qual_reg && eq_d) begin
            lastb_fin = centre_reg;
        end
    end

    assign ready_o = steer_idle_i && !req_reg.start
                  && ((state_reg == S_IDLE) || (final_dig && !last_reg));

    assign req_o = req_reg;

    always_comb begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        window_next = window_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        new_next    = new_reg;
        old_next    = old_reg;
        best_next   = best_reg;
        carry_next  = carry_reg;
        gt_next     = gt_reg;
        eq_next     = eq_reg;
        qual_next   = qual_reg;
        last_next   = last_reg;
        centre_next = centre_reg;
        first_next  = first_reg;
        lastb_next  = lastb_reg;
        req_next    = '0;

        if (state_reg == S_DIGIT) begin
            sum_next   = full_sum;
            new_next   = new_reg >> DIGIT_W;
            old_next   = old_reg >> DIGIT_W;
            best_next  = {bd, best_reg[SUM_W-1:DIGIT_W]};
            carry_next = dsum[DIGIT_W+1:DIGIT_W];
            gt_next    = gt_d;
            eq_next    = eq_d;
            dig_next   = dig_reg + 1'b1;
            if (final_dig) begin
                state_next = S_IDLE;
                first_next = first_fin;
                lastb_next = lastb_fin;
                if (qual_reg && gt_d) begin
                    best_next = full_sum;
                end
                if (last_reg) begin
                    // end of scan: hand off and start over
                    req_next.start      = 1'b1;
                    req_next.first_best = first_fin;
                    req_next.last_best  = lastb_fin;
                    for (int k = 0; k < WINDOW; k++) begin
                        window_next[k] = '0;
                    end
                    count_next = '0;
                    sum_next   = '0;
                    best_next  = '0;
                    first_next = '0;
                    lastb_next = '0;
                end
            end
        end

        if (take_i) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                window_next[k] = window_reg[k+1];
            end
            window_next[WINDOW-1] = clean;
            new_next    = SUM_W'(clean);
            old_next    = SUM_W'(window_reg[0]);
            qual_next   = qual;
            last_next   = last_i;
            centre_next = count_reg[IDX_W-1:0] - IDX_W'(HALF_WIN);
            if (count_reg != COUNT_W'(COUNT_MAX)) begin
                count_next = count_reg + 1'b1;
            end
            dig_next   = '0;
            state_next = S_DIGIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dig_reg   <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                window_reg[k] <= '0;
            end
            count_reg <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            first_reg <= '0;
            lastb_reg <= '0;
            req_reg   <= '0;
            last_reg  <= 1'b0;
            qual_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dig_reg    <= dig_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            best_reg   <= best_next;
            first_reg  <= first_next;
            lastb_reg  <= lastb_next;
            req_reg    <= req_next;
            last_reg   <= last_next;
            qual_reg   <= qual_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_reg    <= new_next;
        old_reg    <= old_next;
        carry_reg  <= carry_next;
        gt_reg     <= gt_next;
        eq_reg     <= eq_next;
        centre_reg <= centre_next;
    end

    `LGH_ASSERT_HOLDS(scan_handoff_idle, req_reg.start, steer_idle_i, "handoff while steer busy")
    `LGH_ASSERT_HOLDS(scan_take_slot, take_i, (state_reg == S_IDLE) || (final_dig && !last_reg), "word taken mid-sum")
    `LGH_ASSERT_HOLDS(scan_cleared, req_reg.start, (count_reg == '0) && (best_reg == '0), "scan state not cleared")

endmodule

`default_nettype wire

FILE: rtl/core/lgh_steer.sv
// ----------------------------------------------------------------------------
// lgh_steer
// Heading, turn rate and speed from the best window span; bit-serial multiply
// and restoring divide, with the result word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_gap_heading_defines.svh"

module lgh_steer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lgh_pkg::steer_cfg_t             cfg_i,
    input  wire lgh_pkg::hole_req_t              req_i,
    output logic                                 idle_o,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lgh_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import lgh_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_TURN, S_DEN, S_NUM, S_DIV, S_HOLD} state_t;

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [REM_W-1:0] ONE_Q28 = REM_W'(1) << 28;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [ANGLE_W-1:0]   acc_reg, acc_next;
    logic [ANGLE_W-1:0]   mcand_reg, mcand_next;
    logic [IDX_W-1:0]     mplier_reg, mplier_next;
    logic [TURN_W-1:0]    turn_reg, turn_next;
    logic [ANGLE_W-1:0]   mag_reg, mag_next;
    logic [REM_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [SPEED_W-1:0]   quot_reg, quot_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [IDX_W:0]       idx_sum;
    logic [REM_W:0]       rem_sh;
    logic                 ge;
    logic                 load;

    assign idx_sum = {1'b0, req_i.first_best} + {1'b0, req_i.last_best};
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign load    = (state_reg == S_HOLD) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        turn_next    = turn_reg;
        mag_next     = mag_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_i.start) begin
                    idx_next    = idx_sum[IDX_W:1];
                    acc_next    = cfg_i.start_angle;
                    mcand_next  = cfg_i.angle_step;
                    mplier_next = idx_sum[IDX_W:1];
                    step_next   = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                // shift-and-add, one index bit a cycle, wraps mod 2^32
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(IDX_W - 1)) begin
                    state_next = S_TURN;
                end
            end
            S_TURN: begin
                turn_next = {{2{acc_reg[ANGLE_W-1]}}, acc_reg}
                          + {acc_reg[ANGLE_W-1], acc_reg, 1'b0};
                mag_next  = acc_reg[ANGLE_W-1] ? (~acc_reg + 1'b1) : acc_reg;
                state_next = S_DEN;
            end
            S_DEN: begin
                den_next   = ONE_Q28 + REM_W'(mag_reg) + {1'b0, mag_reg, 1'b0};
                state_next = S_NUM;
            end
            S_NUM: begin
                // 2^43 + den/2, den below 2^33 so the two never overlap
                num_next   = {1'b1, (NUM_W-REM_W)'(0), den_reg[REM_W-1:1]};
                rem_next   = '0;
                quot_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = ge ? REM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[REM_W-1:0];
                quot_next = {quot_reg[SPEED_W-2:0], ge};
                num_next  = num_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_DATA_W-IDX_W-ANGLE_W-TURN_W-SPEED_W)'(0),
                                    quot_reg, turn_reg, acc_reg, idx_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        turn_reg   <= turn_next;
        mag_reg    <= mag_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        m_data_reg <= m_data_next;
    end

    assign idle_o   = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `LGH_ASSERT_HOLDS(steer_start_idle, req_i.start, state_reg == S_IDLE, "span request while busy")
    `LGH_ASSERT_HOLDS(steer_speed_range, state_reg == S_HOLD, quot_reg <= SPEED_W'(32768), "speed above one")
    `LGH_ASSERT_NEXT(steer_rem_below, (state_reg == S_DIV) && (step_reg == STEP_W'(NUM_W - 1)), rem_reg < den_reg, "divide remainder not reduced")

endmodule

`default_nettype wire

FILE: dv/tb_lidar_gap_heading.sv
// ----------------------------------------------------------------------------
// tb_lidar_gap_heading
// Streams lidar scans into the block, predicts the steering word of every scan
// in-bench, and compares each word field by field with the one it puts out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lidar_gap_heading;

    import lgh_pkg::*;

    localparam int SETTLE_CYCLES    = 100;
    localparam int STALL_LIMIT      = 4000;
    localparam int TURN_GAIN        = 3;
    localparam int SEND_GAP_PCT     = 50;
    localparam int READY_LOW_PCT    = 25;
    localparam int RANDOM_WORDS     = 100;

    typedef enum logic [2:0] {
        REG_RANGE_FLOOR,
        REG_RANGE_CEILING,
        REG_START_ANGLE,
        REG_ANGLE_STEP,
        REG_SCAN_POINTS
    } reg_index_t;

    typedef enum int {
        STYLE_NOISE,
        STYLE_PLATEAU,
        STYLE_EDGE
    } scan_style_t;

    typedef struct {
        logic [IDX_W-1:0]   hole_index;
        logic [ANGLE_W-1:0] heading;
        logic [TURN_W-1:0]  turn_rate;
        logic [SPEED_W-1:0] forward_speed;
    } steer_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [4:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [15:0] range_sample
    logic                  s_tlast  = 1'b0; // scan_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [9:0] hole_index, [41:10] heading,
                                            // [75:42] turn_rate, [91:76] forward_speed

    steer_word_t         steer_due[$];
    logic [SAMPLE_W-1:0] scan_buf[$];
    bit                  gaps_on;
    int                  mismatches;
    int                  quiet_cycles = 0;

    // register shadows
    logic [SAMPLE_W-1:0] floor_q;
    logic [SAMPLE_W-1:0] ceil_q;
    logic [ANGLE_W-1:0]  start_q;
    logic [ANGLE_W-1:0]  step_q;
    logic [COUNT_W-1:0]  points_q;

    // scan state
    logic [SAMPLE_W-1:0] win_q [WINDOW];
    int                  seen_q;
    logic [SUM_W-1:0]    best_q;
    logic [IDX_W-1:0]    first_q;
    logic [IDX_W-1:0]    last_q;

    lidar_gap_heading DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1ns aclk = ~aclk;

    function automatic void clear_scan_state();
        int k;
        for (k = 0; k < WINDOW; k++) win_q[k] = '0;
        seen_q  = 0;
        best_q  = '0;
        first_q = '0;
        last_q  = '0;
    endfunction

    // one accepted sample: slide the window, track the best sum, close the scan
    function automatic void track_sample(logic [SAMPLE_W-1:0] raw, logic scan_end);
        logic [SAMPLE_W-1:0] gated;
        logic [SUM_W-1:0]    sum;
        logic [IDX_W:0]      mid;
        int                  points;
        int                  centre;
        int                  k;
        longint              hs;
        longint unsigned     mag;
        longint unsigned     den;
        steer_word_t         w;
        points = (points_q > MAX_POINTS) ? MAX_POINTS : int'(points_q);
        gated  = (raw > floor_q && raw < ceil_q) ? raw : FIVE_METRES;
        for (k = 0; k < WINDOW - 1; k++) win_q[k] = win_q[k + 1];
        win_q[WINDOW - 1] = gated;
        if (seen_q >= WINDOW - 1) begin
            centre = seen_q - HALF_WIN;
            if (centre >= FIRST_CENTRE && centre + TAIL_GAP <= points) begin
                sum = '0;
                for (k = 0; k < WINDOW; k++) sum += SUM_W'(win_q[k]);
                if (sum > best_q) begin
                    best_q  = sum;
                    first_q = IDX_W'(centre);
                    last_q  = IDX_W'(centre);
                end else if (sum == best_q) begin
                    last_q = IDX_W'(centre);
                end
            end
        end
        if (seen_q < COUNT_MAX) seen_q++;
        if (scan_end) begin
            mid          = ({1'b0, first_q} + {1'b0, last_q}) >> 1;
            w.hole_index = mid[IDX_W-1:0];
            w.heading    = start_q + ANGLE_W'(w.hole_index) * step_q;
            hs           = longint'($signed(w.heading));
            w.turn_rate  = TURN_W'(hs * TURN_GAIN);
            mag          = (hs < 0) ? -hs : hs;
            den          = (64'd1 << 28) + TURN_GAIN * mag;
            w.forward_speed = SPEED_W'(((64'd1 << 43) + den / 2) / den);
            steer_due.push_back(w);
            clear_scan_state();
        end
    endfunction

    task automatic set_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RANGE_FLOOR:   floor_q  = value[SAMPLE_W-1:0];
            REG_RANGE_CEILING: ceil_q   = value[SAMPLE_W-1:0];
            REG_START_ANGLE:   start_q  = value;
            REG_ANGLE_STEP:    step_q   = value;
            REG_SCAN_POINTS:   points_q = value[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // sends scan_buf as one scan, tlast on its final word
    task automatic send_scan();
        int n;
        int i;
        n = scan_buf.size();
        for (i = 0; i < n; i++) begin
            if (gaps_on && $urandom_range(0, 99) < SEND_GAP_PCT) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= scan_buf[i];
            s_tlast  <= (i == n - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            track_sample(scan_buf[i], i == n - 1);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_single(input logic [SAMPLE_W-1:0] value);
        scan_buf.delete();
        scan_buf.push_back(value);
        send_scan();
    endtask

    // block is idle once every word is back and the divider had time to finish
    task automatic wait_drained();
        while (steer_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void fill_scan(int n, scan_style_t style);
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] bump;
        int                  lo;
        int                  span;
        int                  k;
        scan_buf.delete();
        base = SAMPLE_W'($urandom);
        bump = SAMPLE_W'($urandom);
        lo   = $urandom_range(0, n);
        span = $urandom_range(WINDOW, 40);
        for (k = 0; k < n; k++) begin
            case (style)
                STYLE_NOISE: scan_buf.push_back(SAMPLE_W'($urandom));
                // flat floor with one block at a second level: equal sums across the block
                STYLE_PLATEAU: scan_buf.push_back((k >= lo && k < lo + span) ? bump : base);
                default: begin
                    case ($urandom_range(0, 6))
                        0: scan_buf.push_back(floor_q);
                        1: scan_buf.push_back(ceil_q);
                        2: scan_buf.push_back(SAMPLE_W'(floor_q + 1));
                        3: scan_buf.push_back(SAMPLE_W'(ceil_q - 1));
                        4: scan_buf.push_back('0);
                        5: scan_buf.push_back('1);
                        default: scan_buf.push_back(SAMPLE_W'($urandom));
                    endcase
                end
            endcase
        end
    endfunction

    // scans too short to reach a qualifying centre: index 0, heading at start angle
    task automatic test_short_scans();
        send_single('0);
        send_single('1);
        send_single(FIVE_METRES);
        send_single(SAMPLE_W'(1));
        fill_scan(WINDOW, STYLE_EDGE);
        send_scan();
        fill_scan(WINDOW + 3, STYLE_NOISE);
        send_scan();
    endtask

    // default gate and length, scan ends a few centres past the first one
    task automatic test_default_scan();
        wait_drained();
        set_reg(REG_START_ANGLE, $urandom);
        set_reg(REG_ANGLE_STEP, $urandom);
        fill_scan(FIRST_CENTRE + HALF_WIN + 6, STYLE_EDGE);
        send_scan();
    endtask

    task automatic test_range_gate();
        // long stretch with no idling on either side
        gaps_on = 1'b0;
        wait_drained();
        // nothing lies strictly between the bounds: every window ties
        set_reg(REG_RANGE_FLOOR, 2000);
        set_reg(REG_RANGE_CEILING, 2001);
        // two centres qualify, later windows do not count
        set_reg(REG_SCAN_POINTS, FIRST_CENTRE + TAIL_GAP + 1);
        fill_scan(FIRST_CENTRE + HALF_WIN + 6, STYLE_EDGE);
        send_scan();
        gaps_on = 1'b1;
    endtask

    task automatic test_angle_extremes();
        logic [ANGLE_W-1:0] starts [7];
        logic [ANGLE_W-1:0] steps  [7];
        int                 i;
        starts[0] = 32'h8000_0000; steps[0] = 32'h0000_0000;
        starts[1] = 32'h7FFF_FFFF; steps[1] = 32'h0000_0000;
        starts[2] = 32'h0000_0000; steps[2] = 32'h7FFF_FFFF;
        starts[3] = 32'h0000_0000; steps[3] = 32'h8000_0000;
        starts[4] = 32'h7FFF_FFFF; steps[4] = 32'h7FFF_FFFF;
        starts[5] = 32'h8000_0000; steps[5] = 32'hFFFF_FFFF;
        starts[6] = $urandom;      steps[6] = $urandom;
        wait_drained();
        set_reg(REG_RANGE_FLOOR, 0);
        set_reg(REG_RANGE_CEILING, 32'h0000_FFFF);
        // one-word scans: heading is the start angle itself
        for (i = 0; i < 7; i++) begin
            wait_drained();
            set_reg(REG_START_ANGLE, starts[i]);
            set_reg(REG_ANGLE_STEP, steps[i]);
            send_single(SAMPLE_W'($urandom));
        end
    endtask

    task automatic test_scan_points_limits();
        wait_drained();
        set_reg(REG_SCAN_POINTS, 0);
        fill_scan(30, STYLE_NOISE);
        send_scan();
        // above the cap
        wait_drained();
        set_reg(REG_SCAN_POINTS, COUNT_MAX);
        fill_scan(30, STYLE_NOISE);
        send_scan();
    endtask

    task automatic test_random_scans();
        int words;
        int scans;
        int n;
        words = 0;
        scans = 0;
        while (words < RANDOM_WORDS) begin
            if (scans % 4 == 0) begin
                wait_drained();
                set_reg(REG_RANGE_FLOOR, ($urandom_range(0, 9) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, 600));
                set_reg(REG_RANGE_CEILING, ($urandom_range(0, 9) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(30000, 65535));
                set_reg(REG_START_ANGLE, $urandom);
                set_reg(REG_ANGLE_STEP, $urandom_range(0, 1) ? $urandom :
                        32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
                set_reg(REG_SCAN_POINTS, ($urandom_range(0, 9) == 0) ?
                        $urandom_range(0, COUNT_MAX) : $urandom_range(397, 480));
            end else if (scans % 5 == 0) begin
                // hold the sender until every word is back
                wait_drained();
            end
            n = $urandom_range(1, 30);
            fill_scan(n, scan_style_t'($urandom_range(0, 2)));
            send_scan();
            words += n;
            scans++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= READY_LOW_PCT);
    end

    always @(posedge aclk) begin
        steer_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (steer_due.size() == 0) begin
                $error("steering word with none expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = steer_due.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.hole_index) begin
                    $error("hole_index: expected %0d, got %0d",
                           want.hole_index, m_tdata[IDX_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[IDX_W +: ANGLE_W] !== want.heading) begin
                    $error("heading: expected %h, got %h",
                           want.heading, m_tdata[IDX_W +: ANGLE_W]);
                    mismatches++;
                end
                if (m_tdata[IDX_W+ANGLE_W +: TURN_W] !== want.turn_rate) begin
                    $error("turn_rate: expected %h, got %h",
                           want.turn_rate, m_tdata[IDX_W+ANGLE_W +: TURN_W]);
                    mismatches++;
                end
                if (m_tdata[IDX_W+ANGLE_W+TURN_W +: SPEED_W] !== want.forward_speed) begin
                    $error("forward_speed: expected %0d, got %0d",
                           want.forward_speed, m_tdata[IDX_W+ANGLE_W+TURN_W +: SPEED_W]);
                    mismatches++;
                end
            end
        end
    end

    // stall watchdog: no word in, no word out, no register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        gaps_on    = 1'b1;
        mismatches = 0;
        floor_q    = '0;
        ceil_q     = '1;
        start_q    = '0;
        step_q     = '0;
        points_q   = COUNT_W'(720);
        clear_scan_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_scans();
        test_default_scan();
        test_range_gate();
        test_angle_extremes();
        test_scan_points_limits();
        test_random_scans();
        wait_drained();
        if (mismatches == 0 && steer_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lgh_pkg.sv
rtl/core/lgh_scan.sv
rtl/core/lgh_steer.sv
rtl/core/lidar_gap_heading.sv
dv/tb_lidar_gap_heading.sv
